// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge outside of reset.
`define PBR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("%m: check failed");

// Assert an implication in the same cycle.
`define PBR_ASSERT_IMP(label, ante, cons) \
   `PBR_ASSERT(label, (ante) |-> (cons))

// Assert an implication on the following cycle.
`define PBR_ASSERT_NEXT(label, ante, cons) \
   `PBR_ASSERT(label, (ante) |=> (cons))

`endif

// ----- design/pbr_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse beat rate detector package
// Widths, register indexes, shared types and the threshold retune function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbr_pkg;

   localparam int SampleWidth = 8;
   localparam int LevelWidth  = SampleWidth;
   localparam int StepWidth   = 8;
   localparam int HoldWidth   = 14;
   localparam int ScaleWidth  = 5;
   localparam int TimerWidth  = 15;
   localparam int CountWidth  = 13;
   localparam int BpmWidth    = 16;
   localparam int ProdWidth   = ScaleWidth + CountWidth;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = HoldWidth;

   localparam logic [StepWidth-1:0]  StepReset         = StepWidth'(2);
   localparam logic [HoldWidth-1:0]  HoldReset         = HoldWidth'(10000);
   localparam logic [HoldWidth-1:0]  WindowReset       = HoldWidth'(15000);
   localparam logic [ScaleWidth-1:0] ScaleReset        = ScaleWidth'(4);
   localparam logic [LevelWidth-1:0] ThresholdReset    = LevelWidth'(130);
   localparam logic [LevelWidth-1:0] TroughStartReset  = LevelWidth'(250);
   localparam logic [CountWidth-1:0] CountMax          = {CountWidth{1'b1}};
   localparam logic [BpmWidth-1:0]   BpmMax            = {BpmWidth{1'b1}};

   typedef logic [LevelWidth-1:0] level_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_STEP_MS           = 3'd0,
      REG_HOLD_MS           = 3'd1,
      REG_WINDOW_MS         = 3'd2,
      REG_BPM_SCALE         = 3'd3,
      REG_INITIAL_THRESHOLD = 3'd4,
      REG_TROUGH_START      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [StepWidth-1:0]  step_ms;
      logic [HoldWidth-1:0]  hold_ms;
      logic [HoldWidth-1:0]  window_ms;
      logic [ScaleWidth-1:0] bpm_scale;
      level_type             trough_start;
   } cfg_type;

   // Sample position against the threshold after this tick's retune.
   typedef struct packed {
      logic      above;
      logic      below;
      level_type threshold;
   } crossing_type;

   typedef struct packed {
      logic                beat_led;
      logic                report_valid;
      logic [BpmWidth-1:0] bpm;
   } rate_type;

   // Midpoint of peak and trough, unless they sit at their start values or
   // the peak is not above the trough.
   function automatic level_type retune(level_type peak, level_type trough,
                                        level_type start, level_type cur);
      logic                at_start;
      logic [LevelWidth:0] sum;
      at_start = (peak == '0) && (trough == start);
      sum      = {1'b0, peak} + {1'b0, trough};
      if (!at_start && (peak > trough)) begin
         return sum[LevelWidth:1];
      end
      return cur;
   endfunction

endpackage

// ----- design/pbr_level_tracker.sv -----
// ----------------------------------------------------------------------------
// Level tracker
// Peak and trough tracking, adaptive threshold and idle timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbr_level_tracker import pbr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  level_type    sample,
   input  cfg_type      cfg,
   output crossing_type crossing
);

   level_type               thresh_ff, thresh_in;
   level_type               peak_ff, peak_in;
   level_type               trough_ff, trough_in;
   logic [TimerWidth-1:0]   idle_ff, idle_in;

   level_type               peak_1, trough_1, thresh_1, thresh_2;
   logic                    peak_hit, trough_hit, timeout;
   logic [TimerWidth-1:0]   idle_sum, idle_1;

   always_comb begin
      // Peak first, then trough against the threshold the peak left behind.
      peak_hit   = (sample > thresh_ff) && (sample > peak_ff);
      peak_1     = peak_hit ? sample : peak_ff;
      thresh_1   = peak_hit ? retune(peak_1, trough_ff, cfg.trough_start, thresh_ff)
                            : thresh_ff;
      trough_hit = (sample < thresh_1) && (sample < trough_ff);
      trough_1   = trough_hit ? sample : trough_ff;
      thresh_2   = trough_hit ? retune(peak_1, trough_1, cfg.trough_start, thresh_1)
                              : thresh_1;

      idle_sum = idle_ff + TimerWidth'(cfg.step_ms);
      idle_1   = (peak_hit || trough_hit) ? '0 : idle_sum;
      timeout  = idle_1 >= TimerWidth'(cfg.hold_ms);

      // Quiet too long: restart peak and trough, pin the timer at hold.
      peak_in   = timeout ? '0 : peak_1;
      trough_in = timeout ? cfg.trough_start : trough_1;
      idle_in   = timeout ? TimerWidth'(cfg.hold_ms) : idle_1;
      thresh_in = thresh_2;

      crossing.above     = sample > thresh_2;
      crossing.below     = sample < thresh_2;
      crossing.threshold = thresh_2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ThresholdReset;
         peak_ff   <= '0;
         trough_ff <= TroughStartReset;
         idle_ff   <= '0;
      end else if (fire) begin
         thresh_ff <= thresh_in;
         peak_ff   <= peak_in;
         trough_ff <= trough_in;
         idle_ff   <= idle_in;
      end
   end

endmodule

// ----- design/pbr_rate_counter.sv -----
// ----------------------------------------------------------------------------
// Rate counter
// Beat state, beat counting over a window and bpm report at window end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbr_rate_counter import pbr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  crossing_type crossing,
   input  cfg_type      cfg,
   output rate_type     rate
);

   logic                  in_beat_ff, in_beat_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [TimerWidth-1:0] window_ff, window_in;
   logic [BpmWidth-1:0]   bpm_ff, bpm_in;

   logic                  rise, report;
   logic [CountWidth-1:0] count_1;
   logic [TimerWidth-1:0] window_sum;
   logic [ProdWidth-1:0]  prod;

   always_comb begin
      rise    = crossing.above && !in_beat_ff;
      count_1 = (rise && (count_ff < CountMax)) ? count_ff + CountWidth'(1) : count_ff;
      in_beat_in = (rise || in_beat_ff) && !crossing.below;

      window_sum = window_ff + TimerWidth'(cfg.step_ms);
      report     = window_sum >= TimerWidth'(cfg.window_ms);
      prod       = ProdWidth'(cfg.bpm_scale) * ProdWidth'(count_1);

      // Window end: latch the saturated rate and open a new window.
      bpm_in    = !report ? bpm_ff
                : (prod > ProdWidth'(BpmMax)) ? BpmMax : prod[BpmWidth-1:0];
      window_in = report ? '0 : window_sum;
      count_in  = report ? '0 : count_1;

      rate.beat_led     = in_beat_in;
      rate.report_valid = report;
      rate.bpm          = bpm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_beat_ff <= 1'b0;
         count_ff   <= '0;
         window_ff  <= '0;
         bpm_ff     <= '0;
      end else if (fire) begin
         in_beat_ff <= in_beat_in;
         count_ff   <= count_in;
         window_ff  <= window_in;
         bpm_ff     <= bpm_in;
      end
   end

endmodule

// ----- design/pulse_beat_rate_detector.sv -----
// Datapath: a sample accepted into the input register has its result written
// to the result register when the result stage can take it.
// Throughput: one sample per cycle; the combinational update of peak, trough,
// threshold and counters sets the rate, and a full result register stalls it.
// Reset: synchronous; loads register defaults, threshold 130, trough 250.
// ----------------------------------------------------------------------------
// Pulse beat rate detector top level
// Handshake stages, configuration registers, level tracker and rate counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_beat_rate_detector import pbr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SampleWidth-1:0]  req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_beat_led,
   output logic                    rsp_report_valid,
   output logic [BpmWidth-1:0]     rsp_bpm,
   output logic [LevelWidth-1:0]   rsp_threshold,
   input  logic                    csr_write_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   level_type    sample_ff;
   logic         out_valid_ff;
   rate_type     rate_ff;
   level_type    thresh_ff;
   logic         out_ready, fire;
   crossing_type crossing;
   rate_type     rate;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_ready;
   assign req_ready = !in_valid_ff || out_ready;

   // Initial threshold is reloaded with its default on every reset, so a
   // write to it never changes behavior and is not stored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_ms      <= StepReset;
         cfg_ff.hold_ms      <= HoldReset;
         cfg_ff.window_ms    <= WindowReset;
         cfg_ff.bpm_scale    <= ScaleReset;
         cfg_ff.trough_start <= TroughStartReset;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_STEP_MS:      cfg_ff.step_ms      <= csr_wdata[StepWidth-1:0];
            REG_HOLD_MS:      cfg_ff.hold_ms      <= csr_wdata[HoldWidth-1:0];
            REG_WINDOW_MS:    cfg_ff.window_ms    <= csr_wdata[HoldWidth-1:0];
            REG_BPM_SCALE:    cfg_ff.bpm_scale    <= csr_wdata[ScaleWidth-1:0];
            REG_TROUGH_START: cfg_ff.trough_start <= csr_wdata[LevelWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_sample;
      end
      if (fire) begin
         rate_ff   <= rate;
         thresh_ff <= crossing.threshold;
      end
   end

   pbr_level_tracker u_level_tracker (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .sample   (sample_ff),
      .cfg      (cfg_ff),
      .crossing (crossing)
   );

   pbr_rate_counter u_rate_counter (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .crossing (crossing),
      .cfg      (cfg_ff),
      .rate     (rate)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_beat_led     = rate_ff.beat_led;
   assign rsp_report_valid = rate_ff.report_valid;
   assign rsp_bpm          = rate_ff.bpm;
   assign rsp_threshold    = thresh_ff;

endmodule

// ----- design/pbr_checker.sv -----
// ----------------------------------------------------------------------------
// Pulse beat rate detector checker
// Port-level checks on handshake timing and backpressure, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbr_checker import pbr_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_beat_led,
   input logic                    rsp_report_valid,
   input logic [BpmWidth-1:0]     rsp_bpm,
   input logic [LevelWidth-1:0]   rsp_threshold
);

   logic [BpmWidth+LevelWidth+1:0] rsp_payload;

   assign rsp_payload = {rsp_beat_led, rsp_report_valid, rsp_bpm, rsp_threshold};

   // Hold a stalled result transaction.
   `PBR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // A fresh result comes from a request that passed the input register, then the result register.
   `PBR_ASSERT_IMP(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   // Drop req_ready only when a result is stalled at the output.
   `PBR_ASSERT_IMP(a_backpressure, !req_ready, rsp_valid && !rsp_ready)

endmodule

bind pulse_beat_rate_detector pbr_checker u_pbr_checker (.*);
